@@ rtl/tlpg_pkg.sv @@
// Shared types, constants and tables of the tile layer pixel generator.
`timescale 1ns / 1ps
package tlpg_pkg;

   localparam int VRAM_WORDS    = 294912;
   localparam int VRAM_AW       = 19;
   localparam int DEF_SCREEN_WIDTH = 496;
   localparam int DEF_SCREEN_LINES = 384;
   localparam int IN_DEPTH      = 4;
   localparam int OUT_DEPTH     = 8;
   localparam int CSR_IDX_W     = 3;

   localparam logic [VRAM_AW-1:0] LSCROLL_BASE = VRAM_AW'(32'hF6000 / 4);
   localparam logic [VRAM_AW-1:0] LMASK_BASE   = VRAM_AW'(32'hF7000 / 4);
   localparam logic [VRAM_AW-1:0] TMAP_BASE    = VRAM_AW'(32'hF8000 / 4);
   localparam logic [VRAM_AW-1:0] PAL_BASE     = VRAM_AW'(32'h100000 / 4);

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER3     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET0    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET1    = 3'd6;

   localparam logic [7:0] EXPAND5 [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255};

   typedef struct packed {
      logic [7:0]        layer_mode;
      logic [3:0][31:0]  setup;
      logic [1:0][26:0]  offset;
   } cfg_type;

   typedef struct packed {
      logic               wr;
      logic               off;
      logic [VRAM_AW-1:0] addr;
      logic [31:0]        data;
      logic               pair;
      logic [8:0]         line;
      logic [8:0]         x;
   } item_type;

   typedef struct packed {
      logic        above;
      logic        draw;
      logic [31:0] colour;
   } rsp_type;

endpackage

@@ rtl/tlpg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tlpg_ram
   import tlpg_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = VRAM_WORDS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/tlpg_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module tlpg_front
   import tlpg_pkg::*;
#(
   parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
   parameter int SCREEN_LINES = DEF_SCREEN_LINES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tuser,
   input  logic        clearing,
   input  logic        pop,
   output logic        head_valid,
   output item_type    head
);
   localparam int PW = $clog2(IN_DEPTH);

   item_type          q_ff [IN_DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]       cnt_ff, cnt_in;
   item_type          it;
   logic              acc, keep;

   always_comb begin
      it.wr   = ~req_tuser;
      it.addr = req_tdata[18:0];
      it.data = req_tdata[50:19];
      it.pair = req_tdata[51];
      it.line = req_tdata[60:52];
      it.x    = req_tdata[69:61];
      it.off  = (32'(it.line) >= SCREEN_LINES) || (32'(it.x) >= SCREEN_WIDTH);
   end

   assign req_tready = (cnt_ff != (PW+1)'(IN_DEPTH)) && !clearing;
   assign acc        = req_tvalid && req_tready;
   // Writes beyond the memory are dropped here.
   assign keep       = acc && !(it.wr && (32'(it.addr) >= VRAM_WORDS));
   assign head_valid = cnt_ff != '0;
   assign head       = q_ff[rp_ff];

   always_comb begin
      wp_in  = keep ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(keep) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (keep) begin
         q_ff[wp_ff] <= it;
      end
   end
endmodule

@@ rtl/tlpg_back.sv @@
// Back end: memory clearing, write propagation and the pixel fetch pipeline.
`timescale 1ns / 1ps
module tlpg_back
   import tlpg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  item_type head,
   output logic     pop,
   input  logic     rsp_pop,
   output logic     clearing,
   output logic     push,
   output rsp_type  push_data
);
   localparam int RW = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic               valid;
      logic               wr;
      logic               off;
      logic [VRAM_AW-1:0] addr;
      logic [31:0]        data;
      logic               pair;
      logic [8:0]         line;
      logic [8:0]         x;
      logic [1:0]         lay;
      logic               en;
      logic               above;
      logic               mode4;
      logic               lsc;
      logic [8:0]         xs;
      logic [8:0]         ys;
      logic               tsel;
      logic [2:0]         h;
      logic [2:0]         v;
      logic [10:0]        bank;
   } stage_type;

   stage_type          st_ff [1:5];
   stage_type          st_in [1:5];
   logic               clearing_ff, clearing_in;
   logic [VRAM_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [RW-1:0]      reserved_ff, reserved_in;
   logic               launch;
   logic               wen   [5];
   logic [VRAM_AW-1:0] waddr [5];
   logic [31:0]        wdata [5];
   logic [VRAM_AW-1:0] raddr [5];
   logic [31:0]        rdata [5];

   function automatic logic [7:0] add_clamp(input logic [7:0] c, input logic [8:0] o);
      logic signed [10:0] s;
      s = $signed({3'b000, c}) + $signed({{2{o[8]}}, o});
      if (s[10]) begin
         return 8'd0;
      end else if (s[9:8] != 2'b00) begin
         return 8'd255;
      end
      return s[7:0];
   endfunction

   assign clearing = clearing_ff;
   assign launch   = head_valid && !clearing_ff &&
                     (head.wr || (reserved_ff < RW'(OUT_DEPTH)));
   assign pop      = launch;

   always_comb begin
      logic [15:0] mask;
      logic [31:0] setup;
      logic [8:0]  col, row, xs;
      logic [11:0] tn;
      logic [15:0] td;
      logic [31:0] pat;
      logic [14:0] pidx;

      st_in[1]       = '0;
      st_in[1].valid = launch;
      st_in[1].wr    = head.wr;
      st_in[1].off   = head.off;
      st_in[1].addr  = head.addr;
      st_in[1].data  = head.data;
      st_in[1].pair  = head.pair;
      st_in[1].line  = head.line;
      st_in[1].x     = head.x;
      raddr[0]       = LMASK_BASE + VRAM_AW'(head.line);

      st_in[2]       = st_ff[1];
      mask           = st_ff[1].pair ? rdata[0][15:0] : rdata[0][31:16];
      st_in[2].lay   = {st_ff[1].pair, ~mask[~st_ff[1].x[8:5]]};
      setup          = cfg.setup[st_in[2].lay];
      st_in[2].above = cfg.layer_mode[st_in[2].lay] & ~st_ff[1].off;
      st_in[2].en    = setup[31] & ~st_ff[1].off;
      st_in[2].mode4 = cfg.layer_mode[{1'b1, st_in[2].lay}];
      st_in[2].lsc   = setup[15];
      st_in[2].xs    = setup[8:0];
      st_in[2].ys    = setup[24:16];
      raddr[1]       = LSCROLL_BASE | {9'd0, st_in[2].lay, st_ff[1].line[8:1]};

      st_in[3]       = st_ff[2];
      xs             = st_ff[2].lsc ? (st_ff[2].line[0] ? rdata[1][8:0] : rdata[1][24:16])
                                    : st_ff[2].xs;
      col            = st_ff[2].x + xs;
      row            = st_ff[2].line + st_ff[2].ys;
      tn             = {row[8:3], col[8:3]};
      st_in[3].tsel  = tn[0];
      st_in[3].h     = col[2:0];
      st_in[3].v     = row[2:0];
      raddr[2]       = TMAP_BASE | {6'd0, st_ff[2].lay, tn[11:1]};

      st_in[4]       = st_ff[3];
      td             = st_ff[3].tsel ? rdata[2][15:0] : rdata[2][31:16];
      st_in[4].bank  = td[14:4];
      if (st_ff[3].mode4) begin
         raddr[3] = {1'b0, td[13:0], td[15], st_ff[3].v};
      end else begin
         raddr[3] = {1'b0, td[13:0], st_ff[3].v, st_ff[3].h[2]};
      end

      st_in[5]       = st_ff[4];
      pat            = rdata[3];
      if (st_ff[4].mode4) begin
         pidx = {st_ff[4].bank, 4'(pat >> {~st_ff[4].h, 2'b00})};
      end else begin
         pidx = {st_ff[4].bank[10:4], 8'(pat >> {~st_ff[4].h[1:0], 3'b000})};
      end
      raddr[4]       = PAL_BASE | {4'd0, pidx};
   end

   always_comb begin
      logic [31:0] d;
      logic [26:0] o;
      logic [7:0]  a, r, g, b;
      d = rdata[4];
      o = cfg.offset[st_ff[5].pair];
      a = d[15] ? 8'd0 : 8'd255;
      r = EXPAND5[d[4:0]] & a;
      g = EXPAND5[d[9:5]] & a;
      b = EXPAND5[d[14:10]] & a;
      push            = st_ff[5].valid && !st_ff[5].wr;
      push_data.above = st_ff[5].above;
      if (st_ff[5].en) begin
         push_data.draw   = ~d[15];
         push_data.colour = {a, add_clamp(b, o[26:18]), add_clamp(g, o[17:9]),
                             add_clamp(r, o[8:0])};
      end else begin
         push_data.draw   = 1'b0;
         push_data.colour = '0;
      end
   end

   // Each copy of the memory is written when a write reaches the stage that reads it.
   always_comb begin
      wen[0]   = clearing_ff || (launch && head.wr);
      waddr[0] = clearing_ff ? clr_addr_ff : head.addr;
      wdata[0] = clearing_ff ? 32'd0 : head.data;
      for (int k = 1; k < 5; k++) begin
         wen[k]   = clearing_ff || (st_ff[k].valid && st_ff[k].wr);
         waddr[k] = clearing_ff ? clr_addr_ff : st_ff[k].addr;
         wdata[k] = clearing_ff ? 32'd0 : st_ff[k].data;
      end
   end

   for (genvar k = 0; k < 5; k++) begin : g_copy
      tlpg_ram #(.WIDTH(32), .DEPTH(VRAM_WORDS)) u_ram (
         .clock   (clock),
         .wr_en   (wen[k]),
         .wr_addr (waddr[k]),
         .wr_data (wdata[k]),
         .rd_addr (raddr[k]),
         .rd_data (rdata[k])
      );
   end

   always_comb begin
      clr_addr_in = clr_addr_ff + 1'b1;
      clearing_in = clearing_ff && (clr_addr_ff != VRAM_AW'(VRAM_WORDS - 1));
      reserved_in = reserved_ff + RW'(launch && !head.wr) - RW'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         reserved_ff <= '0;
         for (int k = 1; k <= 5; k++) begin
            st_ff[k].valid <= 1'b0;
         end
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         reserved_ff <= reserved_in;
         for (int k = 1; k <= 5; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= RW'(OUT_DEPTH))
      else $error("output reservations exceed the queue depth");
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clearing_ff |=> !clearing_ff)
      else $error("clearing pass restarted without reset");
   a_push_reserved: assert property (@(posedge clock) disable iff (reset)
      push |-> reserved_ff != '0)
      else $error("result produced without a reservation");
endmodule

@@ rtl/tlpg_outq.sv @@
// Output queue that holds finished results until they are taken.
`timescale 1ns / 1ps
module tlpg_outq
   import tlpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  rsp_type     push_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);
   localparam int PW = $clog2(OUT_DEPTH);

   rsp_type       q_ff [OUT_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          pop;

   assign rsp_tvalid = cnt_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {6'd0, q_ff[rp_ff]};

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= push_data;
      end
   end
endmodule

@@ rtl/tile_layer_pixel_generator.sv @@
// Top level of the tile layer pixel generator.
`timescale 1ns / 1ps
// The block takes one item per clock while its input queue has room and no clearing runs: a
// video memory word write or a pixel request. A request passes a pipeline of five dependent
// memory reads (line mask, line scroll, tile word, pattern, palette), each served by its own
// copy of the video memory. Results wait in an eight-entry output queue; items wait in a
// four-entry input queue. After reset the memory is cleared, one word a cycle; no item is
// accepted while it is cleared, and configuration writes are taken at any time.
module tile_layer_pixel_generator
   import tlpg_pkg::*;
#(
   parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
   parameter int SCREEN_LINES = DEF_SCREEN_LINES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // word_address, write_data, layer_pair, line, x_position
   input  logic [71:0]          req_tdata,
   // mode
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // pixel_colour, draw_enable, above_3d
   output logic [39:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);
   cfg_type  cfg_ff, cfg_in;
   item_type head;
   logic     head_valid, pop, clearing, push;
   rsp_type  push_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LAYER_MODE: cfg_in.layer_mode = csr_data[7:0];
            CSR_LAYER0:     cfg_in.setup[0]   = csr_data;
            CSR_LAYER1:     cfg_in.setup[1]   = csr_data;
            CSR_LAYER2:     cfg_in.setup[2]   = csr_data;
            CSR_LAYER3:     cfg_in.setup[3]   = csr_data;
            CSR_OFFSET0:    cfg_in.offset[0]  = csr_data[26:0];
            CSR_OFFSET1:    cfg_in.offset[1]  = csr_data[26:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tlpg_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_LINES(SCREEN_LINES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   tlpg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_pop    (rsp_tvalid && rsp_tready),
      .clearing   (clearing),
      .push       (push),
      .push_data  (push_data)
   );

   tlpg_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

@@ verif/tlpg_checker.sv @@
// Checker of the tile layer pixel generator: predicts every pixel and compares the results.
`timescale 1ns / 1ps
module tlpg_checker
   import tlpg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [71:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [39:0]          rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output int                   fail_count,
   output int                   pixels_waiting,
   output int                   opaque_pixels
);

   bit [31:0] vram_copy [int];
   bit [7:0]  mode_reg;
   bit [31:0] setup_reg [4];
   bit [26:0] offset_reg [2];
   rsp_type   expected_pixels [$];

   initial begin
      fail_count = 0;
      pixels_waiting = 0;
      opaque_pixels = 0;
      mode_reg = '0;
      setup_reg = '{default: '0};
      offset_reg = '{default: '0};
   end

   function automatic bit [31:0] vram_word(int unsigned addr);
      if (addr >= VRAM_WORDS || !vram_copy.exists(addr)) return '0;
      return vram_copy[addr];
   endfunction

   function automatic bit [7:0] clamp_channel(int value);
      if (value > 255) return 8'd255;
      if (value < 0) return 8'd0;
      return value[7:0];
   endfunction

   function automatic rsp_type predict_pixel(bit pair, bit [8:0] line, bit [8:0] x);
      rsp_type     pix;
      int unsigned mask, sel, lay, setup, xs, ys, col, row, tile, td, h, v, base, pat, pidx;
      bit [31:0]   pal;
      int          alpha, r, g, b;
      bit [26:0]   off;
      pix = '0;
      if (line >= DEF_SCREEN_LINES || x >= DEF_SCREEN_WIDTH) return pix;
      mask = (vram_word(int'(LMASK_BASE) + line) >> (pair ? 0 : 16)) & 32'hFFFF;
      sel = ((mask >> (15 - (x >> 5))) & 1) ? 0 : 1;
      lay = pair * 2 + sel;
      setup = setup_reg[lay];
      pix.above = mode_reg[lay];
      if (!setup[31]) return pix;
      if (setup[15])
         xs = (vram_word(int'(LSCROLL_BASE) + lay * 256 + (line >> 1))
               >> (line[0] ? 0 : 16)) & 32'hFFFF;
      else
         xs = setup & 32'h3FF;
      ys = (setup >> 16) & 32'h1FF;
      col = (x + xs) & 32'h1FF;
      row = (line + ys) & 32'h1FF;
      tile = ((row >> 3) & 63) * 64 + ((col >> 3) & 63);
      td = (vram_word(int'(TMAP_BASE) + lay * 32'h800 + (tile >> 1))
            >> ((tile & 1) ? 0 : 16)) & 32'hFFFF;
      h = col & 7;
      v = row & 7;
      if (mode_reg[4 + lay]) begin
         base = (((td & 32'h3FFF) << 1) | ((td >> 15) & 1)) * 8;
         pat = vram_word(base + v);
         pidx = (td & 32'h7FF0) | ((pat >> ((7 - h) * 4)) & 32'hF);
      end else begin
         base = (td & 32'h3FFF) * 16;
         if (h < 4) pat = vram_word(base + v * 2) >> ((3 - h) * 8);
         else pat = vram_word(base + v * 2 + 1) >> ((7 - h) * 8);
         pidx = (td & 32'h7F00) | (pat & 32'hFF);
      end
      pal = vram_word(int'(PAL_BASE) + (pidx & 32'h7FFF));
      alpha = pal[15] ? 0 : 255;
      r = ((int'(pal[4:0]) * 255) / 31) & alpha;
      g = ((int'(pal[9:5]) * 255) / 31) & alpha;
      b = ((int'(pal[14:10]) * 255) / 31) & alpha;
      off = offset_reg[pair];
      pix.colour = {alpha[7:0], clamp_channel(b + int'($signed(off[26:18]))),
                    clamp_channel(g + int'($signed(off[17:9]))),
                    clamp_channel(r + int'($signed(off[8:0])))};
      pix.draw = (alpha != 0);
      return pix;
   endfunction

   task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LAYER_MODE: mode_reg <= csr_data[7:0];
               CSR_LAYER0:     setup_reg[0] <= csr_data;
               CSR_LAYER1:     setup_reg[1] <= csr_data;
               CSR_LAYER2:     setup_reg[2] <= csr_data;
               CSR_LAYER3:     setup_reg[3] <= csr_data;
               CSR_OFFSET0:    offset_reg[0] <= csr_data[26:0];
               CSR_OFFSET1:    offset_reg[1] <= csr_data[26:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (!req_tuser) begin
               if (req_tdata[18:0] < VRAM_WORDS) vram_copy[req_tdata[18:0]] = req_tdata[50:19];
            end else begin
               expected_pixels.push_back(predict_pixel(req_tdata[51], req_tdata[60:52],
                                                       req_tdata[69:61]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unrequested pixel", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[31:0] != want.colour)
                  report_mismatch("pixel_colour", rsp_tdata[31:0], want.colour);
               if (rsp_tdata[32] != want.draw)
                  report_mismatch("draw_enable", 32'(rsp_tdata[32]), 32'(want.draw));
               if (rsp_tdata[33] != want.above)
                  report_mismatch("above_3d", 32'(rsp_tdata[33]), 32'(want.above));
               if (want.draw) opaque_pixels++;
            end
         end
         pixels_waiting = expected_pixels.size();
      end
   end

endmodule

@@ verif/testbench.sv @@
// Top of the tile layer pixel generator testbench: stimulus, register settings and verdict.
`timescale 1ns / 1ps
module testbench;
   import tlpg_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   // word_address, write_data, layer_pair, line, x_position
   logic [71:0]          req_tdata;
   // mode
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // pixel_colour, draw_enable, above_3d
   logic [39:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   int fail_count, pixels_waiting, opaque_pixels;
   int stall_style;
   int idle_cycles;
   int writes_sent, pixels_sent, settings_used;
   int unsigned stall_step;

   localparam int WATCHDOG_LIMIT = 1200000;

   tile_layer_pixel_generator DUT (.*);

   tlpg_checker pixel_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(negedge clock) begin
      stall_step <= stall_step + 1;
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(3) != 0);
         default: rsp_tready <= (stall_step % 7) < 4;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d pixels outstanding", pixels_waiting);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(bit mode, bit [18:0] addr, bit [31:0] data, bit pair,
                            bit [8:0] line, bit [8:0] x);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {2'b0, x, line, pair, data, addr};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (mode) pixels_sent++;
      else writes_sent++;
   endtask

   task automatic write_word(bit [18:0] addr, bit [31:0] data);
      send_item(1'b0, addr, data, 1'b0, '0, '0);
   endtask

   task automatic request_pixel(bit pair, bit [8:0] line, bit [8:0] x);
      send_item(1'b1, 19'($urandom), $urandom, pair, line, x);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, bit [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pixels_waiting != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic apply_setting(bit [7:0] mode, bit [31:0] s0, bit [31:0] s1,
                                bit [31:0] s2, bit [31:0] s3, bit [26:0] o0, bit [26:0] o1);
      wait_idle();
      write_register(CSR_LAYER_MODE, 32'(mode));
      write_register(CSR_LAYER0, s0);
      write_register(CSR_LAYER1, s1);
      write_register(CSR_LAYER2, s2);
      write_register(CSR_LAYER3, s3);
      write_register(CSR_OFFSET0, 32'(o0));
      write_register(CSR_OFFSET1, 32'(o1));
      settings_used++;
   endtask

   function automatic bit [31:0] random_setup();
      bit [31:0] s;
      s = $urandom;
      if ($urandom_range(4) != 0) s[31] = 1'b1;
      return s;
   endfunction

   // Tile halves mostly point at a small pattern area so that written patterns get hit.
   function automatic bit [15:0] random_tile();
      bit [15:0] t;
      t = 16'($urandom);
      if ($urandom_range(7) != 0) t[13:5] = '0;
      return t;
   endfunction

   task automatic random_write();
      bit [18:0] addr;
      bit [31:0] data;
      data = $urandom;
      case ($urandom_range(9))
         0, 1: addr = LMASK_BASE + 19'($urandom_range(511));
         2:    addr = LSCROLL_BASE + 19'($urandom_range(1023));
         3, 4: begin
            addr = TMAP_BASE + 19'($urandom_range(8191));
            data = {random_tile(), random_tile()};
         end
         5, 6: addr = 19'($urandom_range(511));
         7, 8: addr = PAL_BASE + 19'(($urandom_range(1) << 14) + $urandom_range(255));
         default: addr = 19'($urandom);
      endcase
      write_word(addr, data);
   endtask

   task automatic random_phase(int count, bit bursty);
      int gap;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(1)) random_write();
         else
            request_pixel(1'($urandom),
                          9'(($urandom_range(5) == 0) ? $urandom_range(511)
                                                      : $urandom_range(383)),
                          9'(($urandom_range(5) == 0) ? $urandom_range(511)
                                                      : $urandom_range(495)));
         if (bursty && $urandom_range(5) == 0) begin
            gap = $urandom_range(6);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_LAYER_MODE;
      csr_data = '0;
      stall_style = 0;
      stall_step = 0;
      idle_cycles = 0;
      writes_sent = 0;
      pixels_sent = 0;
      settings_used = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: all layers disabled, writes beyond memory, pixels off and on screen.
      write_word(19'(VRAM_WORDS), 32'hFFFF_FFFF);
      write_word(19'h7FFFF, 32'hA5A5_5A5A);
      request_pixel(1'b0, 9'd384, 9'd0);
      request_pixel(1'b1, 9'd0, 9'd496);
      request_pixel(1'b1, 9'h1FF, 9'h1FF);
      request_pixel(1'b0, 9'd383, 9'd495);

      // All four layers enabled, 8-bit mode, zero scroll: opaque and slip checks.
      apply_setting(8'h05, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    27'd0, 27'd0);
      write_word(LMASK_BASE, 32'hFFFF_0000);
      write_word(19'd0, 32'h0102_0304);
      write_word(19'd1, 32'h0506_0708);
      write_word(PAL_BASE, 32'h0000_8000);
      for (int i = 1; i < 9; i++)
         write_word(PAL_BASE + 19'(i), 32'(32'h0000_7FFF - i * 1057));
      for (int i = 0; i < 8; i++) request_pixel(1'b0, 9'd0, 9'(i));
      request_pixel(1'b1, 9'd0, 9'd3);
      request_pixel(1'b0, 9'd1, 9'd0);

      stall_style = 1;
      random_phase(180, 1'b1);
      apply_setting(8'h00, random_setup(), random_setup(), random_setup(), random_setup(),
                    27'd0, 27'd0);
      stall_style = 2;
      random_phase(180, 1'b1);
      apply_setting(8'hFF, random_setup() | 32'h8000, random_setup(), random_setup(),
                    random_setup() | 32'h8000, {9'h0FF, 9'h0FF, 9'h0FF},
                    {9'h0FF, 9'h0FF, 9'h0FF});
      stall_style = 0;
      random_phase(180, 1'b0);
      apply_setting(8'($urandom), random_setup(), random_setup(), random_setup(),
                    random_setup(), {9'h100, 9'h100, 9'h100}, {9'h100, 9'h100, 9'h100});
      stall_style = 1;
      random_phase(180, 1'b1);
      apply_setting(8'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    27'($urandom), 27'($urandom));
      stall_style = 2;
      random_phase(180, 1'b1);
      apply_setting(8'($urandom), random_setup(), random_setup(), random_setup(),
                    random_setup(), 27'($urandom), 27'($urandom));
      stall_style = 1;
      random_phase(180, 1'b0);
      apply_setting(8'($urandom), random_setup(), random_setup(), random_setup(),
                    random_setup(), 27'($urandom), 27'($urandom));
      stall_style = 0;
      random_phase(200, 1'b1);

      wait_idle();
      $display("Sent %0d memory writes and %0d pixel requests under %0d register settings;",
               writes_sent, pixels_sent, settings_used + 1);
      $display("%0d of the checked pixels were opaque.", opaque_pixels);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
